FILE: hdl/u8c_pkg.sv
// Shared types and constants for the UTF-8 codec.
`timescale 1ns / 1ps

package u8c_pkg;

  // Width of the saturating character counter by default
  localparam int COUNT_BITS_DEF = 16;

  // Depth of the job queue between front and back end
  localparam int JOB_DEPTH = 2;

  // Field widths fixed by the item formats
  localparam int IN_VALUE_W   = 32;
  localparam int OUT_VALUE_W  = 22;
  localparam int CHAR_COUNT_W = 16;

  // Direction register codes
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Encoder range limits
  localparam logic [IN_VALUE_W-1:0] CP_1BYTE_LIM = 32'h0000_0080;
  localparam logic [IN_VALUE_W-1:0] CP_2BYTE_LIM = 32'h0000_0800;
  localparam logic [IN_VALUE_W-1:0] CP_3BYTE_LIM = 32'h0001_0000;
  localparam logic [IN_VALUE_W-1:0] CP_MAX_LIM   = 32'h0011_0000;

  // Decoder lead byte thresholds
  localparam logic [7:0] LEAD_CONT = 8'h80;
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] LEAD_4B   = 8'hF0;

  // Input item
  typedef struct packed {
    logic [IN_VALUE_W-1:0] in_value;
    logic                  new_string;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [OUT_VALUE_W-1:0]  out_value;
    logic                    is_error;
    logic                    last;
    logic [CHAR_COUNT_W-1:0] char_count;
    logic                    non_ascii;
  } out_item_t;

  // Job handed from front to back: one to four results that share status
  typedef struct packed {
    logic [3:0][7:0]         data;        // bytes (first in [0]) or a code point
    logic [1:0]              last_idx;    // number of results minus one
    logic                    byte_mode;   // data holds bytes to send one by one
    logic                    is_error;
    logic [CHAR_COUNT_W-1:0] char_count;
    logic                    non_ascii;
  } job_t;

endpackage

FILE: hdl/u8c_front.sv
// Front end: accepts items, tracks decoder and counter state, builds jobs.
`timescale 1ns / 1ps

module u8c_front import u8c_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_valid,
  output job_t     job
);

  logic                  direction_r, direction_nxt;
  logic [1:0]            bytes_left_r, bytes_left_nxt;
  logic [21:0]           code_accum_r, code_accum_nxt;
  logic [COUNT_BITS-1:0] chars_seen_r, chars_seen_nxt;
  logic                  wide_seen_r, wide_seen_nxt;

  logic [COUNT_BITS-1:0] chars_base;
  logic                  wide_base;
  logic                  count_it;
  logic [7:0]            b;
  logic [IN_VALUE_W-1:0] c;
  logic [21:0]           acc_step;
  logic [1:0]            left_step;

  assign b         = item.in_value[7:0];
  assign c         = item.in_value;
  assign acc_step  = {code_accum_r[15:0], b[5:0]};
  assign left_step = bytes_left_r - 2'd1;

  // Classify the item and work out the next state and the job
  always_comb begin
    direction_nxt  = direction_r;
    bytes_left_nxt = bytes_left_r;
    code_accum_nxt = code_accum_r;
    chars_base     = item.new_string ? '0 : chars_seen_r;
    wide_base      = item.new_string ? 1'b0 : wide_seen_r;
    wide_seen_nxt  = wide_base;
    count_it       = 1'b0;
    job_valid      = 1'b0;
    job            = '0;

    if (direction_r == DIR_DECODE) begin
      if (bytes_left_r != 2'd0) begin
        code_accum_nxt = acc_step;
        bytes_left_nxt = left_step;
        if (left_step == 2'd0) begin
          count_it  = 1'b1;
          job_valid = 1'b1;
          job.data  = 32'(acc_step);
        end
      end else if (b < LEAD_CONT) begin
        count_it  = 1'b1;
        job_valid = 1'b1;
        job.data  = 32'(b);
      end else if (b >= LEAD_4B) begin
        code_accum_nxt = 22'(b[3:0]);
        bytes_left_nxt = 2'd3;
        wide_seen_nxt  = 1'b1;
      end else if (b >= LEAD_3B) begin
        code_accum_nxt = 22'(b[3:0]);
        bytes_left_nxt = 2'd2;
        wide_seen_nxt  = 1'b1;
      end else if (b >= LEAD_2B) begin
        code_accum_nxt = 22'(b[4:0]);
        bytes_left_nxt = 2'd1;
        wide_seen_nxt  = 1'b1;
      end else begin
        job_valid    = 1'b1;
        job.is_error = 1'b1;
      end
    end else begin
      job_valid = 1'b1;
      if (c < CP_1BYTE_LIM) begin
        count_it      = 1'b1;
        job.data[0]   = {1'b0, c[6:0]};
        job.byte_mode = 1'b1;
      end else if (c < CP_2BYTE_LIM) begin
        count_it      = 1'b1;
        wide_seen_nxt = 1'b1;
        job.data[0]   = {3'b110, c[10:6]};
        job.data[1]   = {2'b10, c[5:0]};
        job.last_idx  = 2'd1;
        job.byte_mode = 1'b1;
      end else if (c < CP_3BYTE_LIM) begin
        count_it      = 1'b1;
        wide_seen_nxt = 1'b1;
        job.data[0]   = {4'b1110, c[15:12]};
        job.data[1]   = {2'b10, c[11:6]};
        job.data[2]   = {2'b10, c[5:0]};
        job.last_idx  = 2'd2;
        job.byte_mode = 1'b1;
      end else if (c < CP_MAX_LIM) begin
        count_it      = 1'b1;
        wide_seen_nxt = 1'b1;
        job.data[0]   = {5'b11110, c[20:18]};
        job.data[1]   = {2'b10, c[17:12]};
        job.data[2]   = {2'b10, c[11:6]};
        job.data[3]   = {2'b10, c[5:0]};
        job.last_idx  = 2'd3;
        job.byte_mode = 1'b1;
      end else begin
        job.is_error = 1'b1;
      end
    end

    // Saturating count of completed characters
    chars_seen_nxt = chars_base;
    if (count_it && !(&chars_base)) begin
      chars_seen_nxt = chars_base + 1'b1;
    end
    job.char_count = CHAR_COUNT_W'(chars_seen_nxt);
    job.non_ascii  = wide_seen_nxt;
  end

  // Update state on a config write or an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIR_DECODE;
      bytes_left_r <= '0;
      code_accum_r <= '0;
      chars_seen_r <= '0;
      wide_seen_r  <= 1'b0;
    end else if (cfg_we) begin
      direction_r  <= cfg_wdata;
      bytes_left_r <= '0;
      code_accum_r <= '0;
    end else if (accept) begin
      direction_r  <= direction_nxt;
      bytes_left_r <= bytes_left_nxt;
      code_accum_r <= code_accum_nxt;
      chars_seen_r <= chars_seen_nxt;
      wide_seen_r  <= wide_seen_nxt;
    end
  end

endmodule

FILE: hdl/u8c_fifo.sv
// Short job queue between the front and back end.
`timescale 1ns / 1ps

module u8c_fifo import u8c_pkg::*; #(
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/u8c_back.sv
// Back end: unrolls each job into result items, one per cycle while pop is high.
`timescale 1ns / 1ps

module u8c_back import u8c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_avail,
  input  job_t      job,
  output logic      job_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  job_t        cur_r;
  logic        cur_valid_r;
  logic [1:0]  idx_r;
  logic        is_last;
  logic        done;
  logic [31:0] flat;

  assign is_last  = (idx_r == cur_r.last_idx);
  assign done     = pop && cur_valid_r && is_last;
  assign job_take = job_avail && (!cur_valid_r || done);
  assign empty    = !cur_valid_r;
  assign flat     = cur_r.data;

  // Drive the current result
  always_comb begin
    out_item            = '0;
    out_item.out_value  = cur_r.byte_mode ? 22'(cur_r.data[idx_r]) : flat[21:0];
    out_item.is_error   = cur_r.is_error;
    out_item.last       = is_last;
    out_item.char_count = cur_r.char_count;
    out_item.non_ascii  = cur_r.non_ascii;
  end

  // Hold the job register
  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_r <= job;
    end
  end

  // Advance through the job, reload when its last result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (job_take) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop && cur_valid_r) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: hdl/utf8_codec_unit.sv
// Top level of the UTF-8 codec.
//
// Input queue side: drive in_item and raise push; the item is taken at an
// edge where push is high and full is low. Result side: while empty is low
// out_item shows the oldest result; raise pop to take it.
// cfg_we/cfg_wdata write the direction (0 decode, 1 encode); a write drops
// any partly decoded character. Write it only while the block is idle.
// Decode: one byte per item, one result per finished character or bad lead
// byte, none for lead or middle bytes. Encode: one code point per item,
// one to four byte results, the final one marked last.
// The first result of an accepted item passes through the job queue and
// then the output job register before it shows on the outputs.
// Throughput: decode takes one byte per cycle while full is low; encode
// is paced by the back end, which sends one byte a cycle while pop is high.
// A two-entry job queue plus the output job register lets the front keep
// taking items while the receiver stalls; full rises when both are taken.
// Reset (rst_n low, synchronous) selects decode and clears all control state,
// including the character count and the non-ASCII flag; job storage is not cleared.
`timescale 1ns / 1ps

module utf8_codec_unit import u8c_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic accept;
  logic front_valid;
  job_t front_job;
  logic q_full, q_empty, q_rd;
  job_t q_job;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify items
  u8c_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_item),
    .job_valid (front_valid),
    .job       (front_job)
  );

  // Queue jobs
  u8c_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && front_valid),
    .wr_data (front_job),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_job),
    .empty   (q_empty)
  );

  // Send results
  u8c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job       (q_job),
    .job_take  (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
